### hdl/ltit_pkg.sv
// Shared types and constants for the LAP table idle tracker.
`timescale 1ns / 1ps
package ltit_pkg;
  localparam int unsigned LapW   = 24;
  localparam int unsigned IndexW = 52;
  localparam int unsigned RateW  = 28;
  localparam int unsigned TickW  = 32;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned NumW   = 64;
  localparam logic [11:0] TickHz = 12'd3200;
  localparam logic [RateW-1:0] RateReset = 28'd20000000;
  localparam logic [TickW-1:0] IdleReset = 32'd16384;

  localparam logic [0:0] RegSampleRate = 1'b0;
  localparam logic [0:0] RegIdleLimit  = 1'b1;

  // Search request travelling down the chain of cells.
  typedef struct packed {
    logic             vld;
    logic             hit;
    logic [LapW-1:0]  lap;
    logic [TickW-1:0] tick;
  } ltit_srch_t;
endpackage

### hdl/ltit_div.sv
// Bit-serial restoring divider that turns a sample index into a tick count.
`timescale 1ns / 1ps
module ltit_div import ltit_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  logic [IndexW-1:0] index_i,
  input  logic [RateW-1:0]  rate_i,
  output logic              done_o,
  output logic [TickW-1:0]  tick_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0]  num_q, num_d;
  logic [RateW:0]   rem_q, rem_d;
  logic [RateW-1:0] den_q, den_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             run_q, run_d, done_q, done_d;
  logic [NumW-1:0]  prod;
  logic [RateW:0]   trial;

  // Numerator with rounding bias: index*3200 + rate/2, which always fits in 64 bits.
  assign prod = NumW'(index_i) * NumW'(TickHz) + NumW'(rate_i >> 1);
  assign trial = {rem_q[RateW-1:0], num_q[NumW-1]};

  // One quotient bit per cycle.
  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (go_i) begin
      num_d = prod;
      rem_d = '0;
      den_d = rate_i;
      cnt_d = CntW'(NumW);
      run_d = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign tick_o = num_q[TickW-1:0];
endmodule

### hdl/ltit_cell.sv
// One table cell: holds a LAP and its last tick, compares the passing request.
`timescale 1ns / 1ps
module ltit_cell import ltit_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              used_i,
  input  logic              ins_i,
  input  logic [TickW-1:0]  idle_lim_i,
  input  ltit_srch_t        srch_i,
  output ltit_srch_t        srch_o,
  output logic              hit_o,
  output logic              rst_rec_o
);
  logic [LapW-1:0]  key_q;
  logic [TickW-1:0] tick_q;
  logic             match, fwd;
  ltit_srch_t       srch_q, srch_d;

  assign match = srch_i.vld && !srch_i.hit && used_i && (key_q == srch_i.lap);
  assign fwd   = srch_i.tick >= tick_q;

  // A request that has matched or been stored is marked as served.
  always_comb begin
    srch_d = srch_i;
    if (match || ins_i) begin
      srch_d.hit = 1'b1;
    end
  end

  // Key and tick update on an insert; only the tick updates on a hit going forward.
  always_ff @(posedge clk_i) begin
    if (ins_i) begin
      key_q  <= srch_i.lap;
      tick_q <= srch_i.tick;
    end else if (match && fwd) begin
      tick_q <= srch_i.tick;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srch_q <= '0;
    end else begin
      srch_q <= srch_d;
    end
  end

  assign srch_o    = srch_q;
  assign hit_o     = match;
  assign rst_rec_o = match && fwd && ((srch_i.tick - tick_q) > idle_lim_i);
endmodule

### hdl/lap_table_idle_tracker_top.sv
// Top level: configuration registers, tick divider and chain of table cells.
// A start runs the divider, then loads the chain head; the request then passes
// through the cells in order, one register per cell, and the result for slot k
// is registered when it reaches cell k, the table-full verdict when the last cell
// neither matches nor takes it. A new packet waits for the last; busy holds off start.
// Results appear for one cycle on result_vld_o; the receiver cannot stall.
// Reset empties the table and loads default register values; no clearing pass.
`timescale 1ns / 1ps
module lap_table_idle_tracker_top import ltit_pkg::*; #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [LapW-1:0]   lap_i,
  input  logic [IndexW-1:0] sample_index_i,
  output logic              result_vld_o,
  output logic [SlotW-1:0]  slot_o,
  output logic              created_o,
  output logic              reset_recovery_o,
  output logic              status_o,
  output logic [TickW-1:0]  tick_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned UseW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_WALK} state_e;

  state_e           state_q;
  logic [RateW-1:0] rate_q;
  logic [TickW-1:0] idle_q;
  logic [UseW-1:0]  used_q;
  logic [LapW-1:0]  lap_q;
  logic [IdxW:0]    pos_q;
  logic             div_go, div_done, wr, head_vld;
  logic [TickW-1:0] div_tick;

  ltit_srch_t       chain [ENTRIES+1];
  logic [ENTRIES-1:0] hit, rrec, ins, used_v;
  logic             found, any_rrec;
  logic [IdxW-1:0]  hit_idx;

  // Register writes and reads.
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RateReset;
      idle_q <= IdleReset;
    end else if (wr && paddr[2] == RegSampleRate) begin
      rate_q <= pwdata[RateW-1:0];
    end else if (wr && paddr[2] == RegIdleLimit) begin
      idle_q <= pwdata;
    end
  end
  always_comb begin
    case (paddr[2])
      RegSampleRate: prdata = 32'(rate_q);
      default:       prdata = idle_q;
    endcase
  end

  assign div_go = start && !busy && (rate_q != '0);

  ltit_div u_div (
    .clk_i, .rst_ni, .go_i(div_go), .index_i(sample_index_i), .rate_i(rate_q),
    .done_o(div_done), .tick_o(div_tick)
  );

  // Head of the chain is loaded in the first walk cycle, so the sequencer sees cell 0.
  assign head_vld = (state_q == S_WALK) && (pos_q == '0);
  assign chain[0] = {head_vld, 1'b0, lap_q, tick_o};

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    assign used_v[g] = UseW'(g) < used_q;
    // Insert on reaching the first free slot without a hit.
    assign ins[g] = chain[g].vld && !chain[g].hit && (UseW'(g) == used_q);
    ltit_cell u_cell (
      .clk_i, .rst_ni, .used_i(used_v[g]), .ins_i(ins[g]), .idle_lim_i(idle_q),
      .srch_i(chain[g]), .srch_o(chain[g+1]), .hit_o(hit[g]), .rst_rec_o(rrec[g])
    );
  end

  // At most one cell is active each cycle, so a simple OR gathers its flags.
  always_comb begin
    found   = |hit;
    any_rrec = |rrec;
    hit_idx = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      if (hit[k] || ins[k]) hit_idx = IdxW'(k);
    end
  end

  assign busy = (state_q != S_IDLE);

  // Sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      used_q           <= '0;
      result_vld_o     <= 1'b0;
      pos_q            <= '0;
      lap_q            <= '0;
      slot_o           <= '0;
      created_o        <= 1'b0;
      reset_recovery_o <= 1'b0;
      status_o         <= 1'b0;
      tick_o           <= '0;
    end else begin
      result_vld_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (div_go) begin
            lap_q   <= lap_i;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            pos_q   <= '0;
            tick_o  <= div_tick;
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (found || (|ins)) begin
            result_vld_o     <= 1'b1;
            slot_o           <= SlotW'(hit_idx);
            created_o        <= !found;
            reset_recovery_o <= any_rrec;
            status_o         <= 1'b0;
            if (!found) used_q <= used_q + 1'b1;
            state_q          <= S_IDLE;
          end else if (pos_q == (IdxW+1)'(ENTRIES - 1)) begin
            result_vld_o     <= 1'b1;
            slot_o           <= '0;
            created_o        <= 1'b0;
            reset_recovery_o <= 1'b0;
            status_o         <= 1'b1;
            state_q          <= S_IDLE;
          end else begin
            pos_q <= pos_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
